// File: design/cirf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cirf_pkg;

    localparam int EXT_BYTES = 21;
    localparam int EXT_AW    = $clog2(EXT_BYTES);

    localparam logic [2:0] OP_WRITE_EXT  = 3'd0;
    localparam logic [2:0] OP_DATA       = 3'd1;
    localparam logic [2:0] OP_STATUS     = 3'd2;
    localparam logic [2:0] OP_ACK        = 3'd3;
    localparam logic [2:0] OP_GET_REPORT = 3'd4;

    localparam logic [2:0] K_DATA   = 3'd0;
    localparam logic [2:0] K_STATUS = 3'd1;
    localparam logic [2:0] K_ACK    = 3'd2;
    localparam logic [2:0] K_ZERO   = 3'd3;
    localparam logic [2:0] K_ERR    = 3'd4;

    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_BAD_TYPE = 2'd1;
    localparam logic [1:0] E_BAD_ID   = 2'd2;

    localparam logic [7:0] ID_STATUS  = 8'h20;
    localparam logic [7:0] ID_READ    = 8'h21;
    localparam logic [7:0] ID_ACK     = 8'h22;
    localparam logic [3:0] ID_DATA_HI = 4'h3;
    localparam logic [1:0] MODE_HI    = 2'b11;
    localparam logic [7:0] IR_FILL    = 8'hFF;

    localparam logic [4:0] STATUS_SIZE = 5'd6;
    localparam logic [4:0] ACK_SIZE    = 5'd4;
    localparam logic [4:0] READ_SIZE   = 5'd21;

    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_LEDS    = 2'd1;
    localparam logic [1:0] CFG_IR      = 2'd2;
    localparam logic [1:0] CFG_SPEAKER = 2'd3;

    localparam logic [5:0] MODE_RESET = 6'h30;

    typedef struct packed {
        logic [4:0] size;
        logic       has_buttons;
        logic       has_accel;
        logic [4:0] accel_at;
        logic [4:0] ir_at;
        logic [4:0] ir_len;
        logic [4:0] ext_at;
        logic [4:0] ext_len;
    } t_layout;

    typedef struct packed {
        logic load;
        logic store_wr;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic plan_ok;
        logic is_write;
        logic last;
        logic out_free;
    } t_dp_sts;

    function automatic t_layout cirf_layout(input logic [3:0] idx);
        t_layout l;
        l = '0;
        unique case (idx)
            4'h0: l = '{5'd2,  1'b1, 1'b0, 5'd0, 5'd0, 5'd0,  5'd0,  5'd0};
            4'h1: l = '{5'd5,  1'b1, 1'b1, 5'd2, 5'd0, 5'd0,  5'd0,  5'd0};
            4'h2: l = '{5'd10, 1'b1, 1'b0, 5'd0, 5'd0, 5'd0,  5'd2,  5'd8};
            4'h3: l = '{5'd17, 1'b1, 1'b1, 5'd2, 5'd5, 5'd12, 5'd0,  5'd0};
            4'h4: l = '{5'd21, 1'b1, 1'b0, 5'd0, 5'd0, 5'd0,  5'd2,  5'd19};
            4'h5: l = '{5'd21, 1'b1, 1'b1, 5'd2, 5'd0, 5'd0,  5'd5,  5'd16};
            4'h6: l = '{5'd21, 1'b1, 1'b0, 5'd0, 5'd2, 5'd10, 5'd12, 5'd9};
            4'h7: l = '{5'd21, 1'b1, 1'b1, 5'd2, 5'd5, 5'd10, 5'd15, 5'd6};
            4'h8, 4'h9, 4'hA, 4'hB, 4'hC: l = '0;
            4'hD: l = '{5'd21, 1'b0, 1'b0, 5'd0, 5'd0, 5'd0,  5'd0,  5'd21};
            4'hE, 4'hF: l = '{5'd21, 1'b1, 1'b0, 5'd0, 5'd2, 5'd19, 5'd0, 5'd0};
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

// File: design/cirf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cirf_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  cirf_pkg::t_dp_sts i_sts,
    output cirf_pkg::t_dp_cmd o_cmd
);
    import cirf_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd.load     = accept && i_sts.plan_ok;
        o_cmd.store_wr = accept && i_sts.is_write;
        o_cmd.step     = (r_state == S_EMIT) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (o_cmd.step && i_sts.last) n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: design/cirf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module cirf_datapath (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  cirf_pkg::t_dp_cmd i_cmd,
    output cirf_pkg::t_dp_sts o_sts,
    input  wire               i_cfg_wr_en,
    input  wire  [1:0]        i_cfg_index,
    input  wire  [5:0]        i_cfg_data,
    input  wire  [2:0]        i_opcode,
    input  wire  [7:0]        i_req_id,
    input  wire               i_report_is_input,
    input  wire  [15:0]       i_buttons,
    input  wire  [7:0]        i_accel_x,
    input  wire  [7:0]        i_accel_y,
    input  wire  [7:0]        i_accel_z,
    input  wire  [7:0]        i_batt_level,
    input  wire               i_batt_low,
    input  wire  [4:0]        i_ext_index,
    input  wire  [7:0]        i_byte_value,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic [7:0]        o_sent_id,
    output logic [4:0]        o_byte_index,
    output logic [7:0]        o_data_byte,
    output logic              o_last_byte,
    output logic [1:0]        o_error_code
);
    import cirf_pkg::*;

    // configuration
    logic [5:0] r_mode;
    logic [3:0] r_leds;
    logic       r_ir_en;
    logic       r_spk_en;

    logic [7:0] r_store [EXT_BYTES];

    // latched request
    logic [2:0]  r_kind;
    logic [4:0]  r_size;
    logic [7:0]  r_id;
    logic [3:0]  r_lidx;
    logic [1:0]  r_err;
    logic [15:0] r_buttons;
    logic [7:0]  r_ax;
    logic [7:0]  r_ay;
    logic [7:0]  r_az;
    logic [7:0]  r_batt;
    logic        r_blow;
    logic [7:0]  r_rid;
    logic [7:0]  r_bval;
    logic [4:0]  r_k;

    // decode of the incoming beat
    logic [2:0] p_kind;
    logic [4:0] p_size;
    logic [7:0] p_id;
    logic [3:0] p_lidx;
    logic [1:0] p_err;
    logic       p_ok;
    t_layout    mode_lay;
    t_layout    id_lay;

    always_comb begin
        mode_lay = cirf_layout(r_mode[3:0]);
        id_lay   = cirf_layout(i_req_id[3:0]);
        p_kind   = K_ZERO;
        p_size   = 5'd1;
        p_id     = i_req_id;
        p_lidx   = i_req_id[3:0];
        p_err    = E_NONE;
        p_ok     = 1'b0;
        unique case (i_opcode)
            OP_DATA: begin
                p_kind = K_DATA;
                p_size = mode_lay.size;
                p_id   = {2'b00, r_mode};
                p_lidx = r_mode[3:0];
                p_ok   = (r_mode[5:4] == MODE_HI) && (mode_lay.size != 5'd0);
            end
            OP_STATUS: begin
                p_kind = K_STATUS;
                p_size = STATUS_SIZE;
                p_id   = ID_STATUS;
                p_ok   = 1'b1;
            end
            OP_ACK: begin
                p_kind = K_ACK;
                p_size = ACK_SIZE;
                p_id   = ID_ACK;
                p_ok   = 1'b1;
            end
            OP_GET_REPORT: begin
                p_ok = 1'b1;
                priority if (!i_report_is_input) begin
                    p_kind = K_ERR;
                    p_err  = E_BAD_TYPE;
                end else if (i_req_id == ID_STATUS) begin
                    p_kind = K_STATUS;
                    p_size = STATUS_SIZE;
                end else if (i_req_id == ID_READ) begin
                    p_size = READ_SIZE;
                end else if (i_req_id == ID_ACK) begin
                    p_size = ACK_SIZE;
                end else if ((i_req_id[7:4] == ID_DATA_HI) && (id_lay.size >= 5'd2)) begin
                    p_kind = K_DATA;
                    p_size = id_lay.size;
                end else begin
                    p_kind = K_ERR;
                    p_err  = E_BAD_ID;
                end
            end
            default: p_ok = 1'b0;
        endcase
    end

    // byte at position r_k
    t_layout    lay;
    logic [4:0] ext_n;
    logic [4:0] d_acc;
    logic [4:0] d_ir;
    logic [4:0] d_ext;
    logic [7:0] byte_d;

    always_comb begin
        lay    = cirf_layout(r_lidx);
        ext_n  = (lay.ext_len > 5'(EXT_BYTES)) ? 5'(EXT_BYTES) : lay.ext_len;
        d_acc  = r_k - lay.accel_at;
        d_ir   = r_k - lay.ir_at;
        d_ext  = r_k - lay.ext_at;
        byte_d = 8'h00;
        unique case (r_kind)
            K_DATA: begin
                if (lay.has_buttons && r_k == 5'd0) byte_d = r_buttons[15:8];
                if (lay.has_buttons && r_k == 5'd1) byte_d = r_buttons[7:0];
                if (lay.has_accel && r_k >= lay.accel_at && d_acc < 5'd3) begin
                    unique case (d_acc)
                        5'd0:    byte_d = r_ax;
                        5'd1:    byte_d = r_ay;
                        default: byte_d = r_az;
                    endcase
                end
                if (r_k >= lay.ir_at && d_ir < lay.ir_len) byte_d = IR_FILL;
                if (r_k >= lay.ext_at && d_ext < ext_n) byte_d = r_store[d_ext[EXT_AW-1:0]];
            end
            K_STATUS: begin
                unique case (r_k)
                    5'd0:    byte_d = r_buttons[15:8];
                    5'd1:    byte_d = r_buttons[7:0];
                    5'd2:    byte_d = {r_leds, r_ir_en, r_spk_en, 1'b0, r_blow};
                    5'd5:    byte_d = r_batt;
                    default: byte_d = 8'h00;
                endcase
            end
            K_ACK: begin
                unique case (r_k)
                    5'd0:    byte_d = r_buttons[15:8];
                    5'd1:    byte_d = r_buttons[7:0];
                    5'd2:    byte_d = r_rid;
                    5'd3:    byte_d = r_bval;
                    default: byte_d = 8'h00;
                endcase
            end
            default: byte_d = 8'h00;
        endcase
    end

    always_comb begin
        o_sts.plan_ok  = p_ok;
        o_sts.is_write = (i_opcode == OP_WRITE_EXT);
        o_sts.last     = ((r_k + 5'd1) == r_size);
        o_sts.out_free = !o_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RESET;
            r_leds   <= 4'd0;
            r_ir_en  <= 1'b0;
            r_spk_en <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_MODE:    r_mode   <= i_cfg_data;
                CFG_LEDS:    r_leds   <= i_cfg_data[3:0];
                CFG_IR:      r_ir_en  <= i_cfg_data[0];
                CFG_SPEAKER: r_spk_en <= i_cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < EXT_BYTES; i++) r_store[i] <= 8'h00;
        end else if (i_cmd.store_wr && (i_ext_index < 5'(EXT_BYTES))) begin
            r_store[i_ext_index[EXT_AW-1:0]] <= i_byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= p_kind;
            r_size    <= p_size;
            r_id      <= p_id;
            r_lidx    <= p_lidx;
            r_err     <= p_err;
            r_buttons <= i_buttons;
            r_ax      <= i_accel_x;
            r_ay      <= i_accel_y;
            r_az      <= i_accel_z;
            r_batt    <= i_batt_level;
            r_blow    <= i_batt_low;
            r_rid     <= i_req_id;
            r_bval    <= i_byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 5'd0;
        end else if (i_cmd.load) begin
            r_k <= 5'd0;
        end else if (i_cmd.step) begin
            r_k <= r_k + 5'd1;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            o_sent_id    <= r_id;
            o_byte_index <= r_k;
            o_data_byte  <= byte_d;
            o_last_byte  <= o_sts.last;
            o_error_code <= r_err;
        end
    end

endmodule

`default_nettype wire

// File: design/controller_input_report_framer.sv
// Controller input report framer.
// Input channel (i_in_valid / o_in_stall): one request beat per item. Opcode 0
// writes the extension byte store and emits nothing; opcodes 1..4 emit a data,
// status, ack or get-report response; other opcodes and an unusable reporting
// mode emit nothing.
// Output channel (o_out_valid / i_out_stall): one beat per payload byte, with
// id, byte index, byte, last flag and error code. An error response is a
// single beat with last set.
// Config port: i_cfg_wr_en writes i_cfg_data into register i_cfg_index
// (0 mode, 1 leds, 2 camera enable, 3 speaker enable) in the same cycle.
// Flow: an accepted request is latched into the request registers, and each
// byte then goes through the output beat register, one byte per cycle while
// the output is not stalled; a request that emits nothing leaves the block
// idle. The rate is set by the single byte counter that walks the report.
// A stall on the output holds the current beat and the byte counter; the
// input is stalled until the last byte of a report is registered.
// Reset clears the mode to 0x30, the other config registers, the byte counter
// and the extension store to zero, and drops o_out_valid.
`timescale 1ns / 1ps
`default_nettype none

module controller_input_report_framer (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_wr_en,
    input  wire  [1:0] i_cfg_index,
    input  wire  [5:0] i_cfg_data,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire  [2:0] i_opcode,
    input  wire  [7:0] i_req_id,
    input  wire        i_report_is_input,
    input  wire [15:0] i_buttons,
    input  wire  [7:0] i_accel_x,
    input  wire  [7:0] i_accel_y,
    input  wire  [7:0] i_accel_z,
    input  wire  [7:0] i_batt_level,
    input  wire        i_batt_low,
    input  wire  [4:0] i_ext_index,
    input  wire  [7:0] i_byte_value,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [7:0] o_sent_id,
    output logic [4:0] o_byte_index,
    output logic [7:0] o_data_byte,
    output logic       o_last_byte,
    output logic [1:0] o_error_code
);
    import cirf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    cirf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cirf_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_opcode),
        .i_req_id          (i_req_id),
        .i_report_is_input (i_report_is_input),
        .i_buttons         (i_buttons),
        .i_accel_x         (i_accel_x),
        .i_accel_y         (i_accel_y),
        .i_accel_z         (i_accel_z),
        .i_batt_level      (i_batt_level),
        .i_batt_low        (i_batt_low),
        .i_ext_index       (i_ext_index),
        .i_byte_value      (i_byte_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_sent_id         (o_sent_id),
        .o_byte_index      (o_byte_index),
        .o_data_byte       (o_data_byte),
        .o_last_byte       (o_last_byte),
        .o_error_code      (o_error_code)
    );

endmodule

`default_nettype wire

// File: design/cirf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cirf_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_out_valid,
    input wire       i_out_stall,
    input wire [7:0] o_sent_id,
    input wire [4:0] o_byte_index,
    input wire [7:0] o_data_byte,
    input wire       o_last_byte,
    input wire [1:0] o_error_code
);
    import cirf_pkg::*;

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data_byte)
            && $stable(o_byte_index) && $stable(o_last_byte))
        else $error("output beat changed under stall");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_error_code != E_NONE) |->
            o_last_byte && (o_byte_index == 5'd0) && (o_data_byte == 8'h00))
        else $error("error beat malformed");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_error_code == E_NONE) || (o_error_code == E_BAD_TYPE)
            || (o_error_code == E_BAD_ID))
        else $error("undefined error code");

    // report bytes follow back to back once taken
    a_next_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_byte |=> o_out_valid
            && (o_byte_index == $past(o_byte_index) + 5'd1)
            && (o_sent_id == $past(o_sent_id)))
        else $error("report bytes not contiguous");

endmodule

bind controller_input_report_framer cirf_checker u_cirf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_sent_id    (o_sent_id),
    .o_byte_index (o_byte_index),
    .o_data_byte  (o_data_byte),
    .o_last_byte  (o_last_byte),
    .o_error_code (o_error_code)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import cirf_pkg::*;

    localparam int STORE_DEPTH    = EXT_BYTES;
    localparam int MAX_BYTES      = 21;
    localparam int SETTLE_CYCLES  = 30;
    localparam int STUCK_LIMIT    = 2000;
    localparam int PHASES         = 13;
    localparam int PHASE_REQS     = 31;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  req_id;
        logic        report_is_input;
        logic [15:0] buttons;
        logic [7:0]  accel_x;
        logic [7:0]  accel_y;
        logic [7:0]  accel_z;
        logic [7:0]  batt_level;
        logic        batt_low;
        logic [4:0]  ext_index;
        logic [7:0]  byte_value;
    } t_request;

    typedef struct packed {
        logic [7:0] id;
        logic [4:0] idx;
        logic [7:0] data;
        logic       last;
        logic [1:0] err;
    } t_report_beat;

    typedef struct packed {
        logic [4:0] size;
        logic       buttons;
        logic       accel;
        logic [4:0] accel_at;
        logic [4:0] ir_at;
        logic [4:0] ir_len;
        logic [4:0] ext_at;
        logic [4:0] ext_len;
    } t_frame_layout;

    typedef enum logic [2:0] {
        FRAME_NONE, FRAME_DATA, FRAME_STATUS, FRAME_ACK, FRAME_ZERO, FRAME_ERROR
    } t_frame_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [5:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic [2:0]  i_opcode = '0;
    logic [7:0]  i_req_id = '0;
    logic        i_report_is_input = 1'b0;
    logic [15:0] i_buttons = '0;
    logic [7:0]  i_accel_x = '0;
    logic [7:0]  i_accel_y = '0;
    logic [7:0]  i_accel_z = '0;
    logic [7:0]  i_batt_level = '0;
    logic        i_batt_low = 1'b0;
    logic [4:0]  i_ext_index = '0;
    logic [7:0]  i_byte_value = '0;
    logic        i_out_stall = 1'b0;
    wire         o_in_stall;
    wire         o_out_valid;
    wire  [7:0]  o_sent_id;
    wire  [4:0]  o_byte_index;
    wire  [7:0]  o_data_byte;
    wire         o_last_byte;
    wire  [1:0]  o_error_code;

    controller_input_report_framer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_req_id          (i_req_id),
        .i_report_is_input (i_report_is_input),
        .i_buttons         (i_buttons),
        .i_accel_x         (i_accel_x),
        .i_accel_y         (i_accel_y),
        .i_accel_z         (i_accel_z),
        .i_batt_level      (i_batt_level),
        .i_batt_low        (i_batt_low),
        .i_ext_index       (i_ext_index),
        .i_byte_value      (i_byte_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_sent_id         (o_sent_id),
        .o_byte_index      (o_byte_index),
        .o_data_byte       (o_data_byte),
        .o_last_byte       (o_last_byte),
        .o_error_code      (o_error_code)
    );

    always #6 i_clk = ~i_clk;

    logic [7:0]   ext_store [STORE_DEPTH];
    logic [5:0]   mode_q = MODE_RESET;
    logic [3:0]   leds_q = '0;
    logic         ir_q = 1'b0;
    logic         spk_q = 1'b0;

    t_request     pending_reqs [$];
    t_report_beat expected_beats [$];
    int           reqs_queued = 0;
    int           reqs_accepted = 0;
    int           mismatch_count = 0;
    int           stuck_cycles = 0;
    int           idle_pct = 0;
    bit           timed_out = 1'b0;

    initial begin
        for (int k = 0; k < STORE_DEPTH; k++) ext_store[k] = '0;
    end

    function automatic t_frame_layout layout_for_id(input logic [7:0] id);
        t_frame_layout l;
        l = '0;
        if (id[7:4] == ID_DATA_HI) begin
            case (id[3:0])
                4'h0: l = {5'd2,  1'b1, 1'b0, 5'd0, 5'd0, 5'd0,  5'd0,  5'd0};
                4'h1: l = {5'd5,  1'b1, 1'b1, 5'd2, 5'd0, 5'd0,  5'd0,  5'd0};
                4'h2: l = {5'd10, 1'b1, 1'b0, 5'd0, 5'd0, 5'd0,  5'd2,  5'd8};
                4'h3: l = {5'd17, 1'b1, 1'b1, 5'd2, 5'd5, 5'd12, 5'd0,  5'd0};
                4'h4: l = {5'd21, 1'b1, 1'b0, 5'd0, 5'd0, 5'd0,  5'd2,  5'd19};
                4'h5: l = {5'd21, 1'b1, 1'b1, 5'd2, 5'd0, 5'd0,  5'd5,  5'd16};
                4'h6: l = {5'd21, 1'b1, 1'b0, 5'd0, 5'd2, 5'd10, 5'd12, 5'd9};
                4'h7: l = {5'd21, 1'b1, 1'b1, 5'd2, 5'd5, 5'd10, 5'd15, 5'd6};
                4'hD: l = {5'd21, 1'b0, 1'b0, 5'd0, 5'd0, 5'd0,  5'd0,  5'd21};
                4'hE, 4'hF: l = {5'd21, 1'b1, 1'b0, 5'd0, 5'd2, 5'd19, 5'd0, 5'd0};
                default: l = '0;
            endcase
        end
        return l;
    endfunction

    task automatic predict_report(input t_request r);
        logic [7:0]    bytes [MAX_BYTES];
        t_frame_layout l;
        t_frame_kind   kind;
        t_report_beat  b;
        logic [7:0]    id;
        logic [1:0]    err;
        int            size;
        int            n;
        kind = FRAME_NONE;
        id   = '0;
        err  = E_NONE;
        size = 0;
        for (int k = 0; k < MAX_BYTES; k++) bytes[k] = '0;
        case (r.opcode)
            OP_WRITE_EXT: begin
                if (r.ext_index < STORE_DEPTH) ext_store[r.ext_index] = r.byte_value;
            end
            OP_DATA: begin
                kind = FRAME_DATA;
                id   = {2'b00, mode_q};
            end
            OP_STATUS: begin
                kind = FRAME_STATUS;
                id   = ID_STATUS;
            end
            OP_ACK: begin
                kind = FRAME_ACK;
                id   = ID_ACK;
            end
            OP_GET_REPORT: begin
                id = r.req_id;
                if (!r.report_is_input) begin
                    kind = FRAME_ERROR;
                    err  = E_BAD_TYPE;
                end else if (id == ID_STATUS) begin
                    kind = FRAME_STATUS;
                end else if (id == ID_READ) begin
                    kind = FRAME_ZERO;
                    size = READ_SIZE;
                end else if (id == ID_ACK) begin
                    kind = FRAME_ZERO;
                    size = ACK_SIZE;
                end else begin
                    kind = FRAME_DATA;
                end
            end
            default: ;
        endcase

        if (kind == FRAME_DATA) begin
            l    = layout_for_id(id);
            size = l.size;
            if (l.buttons) begin
                bytes[0] = r.buttons[15:8];
                bytes[1] = r.buttons[7:0];
            end
            if (l.accel) begin
                bytes[l.accel_at]     = r.accel_x;
                bytes[l.accel_at + 1] = r.accel_y;
                bytes[l.accel_at + 2] = r.accel_z;
            end
            for (int k = 0; k < l.ir_len; k++) bytes[l.ir_at + k] = IR_FILL;
            n = (l.ext_len > STORE_DEPTH) ? STORE_DEPTH : l.ext_len;
            for (int k = 0; k < n; k++) bytes[l.ext_at + k] = ext_store[k];
            if (r.opcode == OP_GET_REPORT && size < 2) begin
                kind = FRAME_ERROR;
                err  = E_BAD_ID;
            end
        end else if (kind == FRAME_STATUS) begin
            size     = STATUS_SIZE;
            bytes[0] = r.buttons[15:8];
            bytes[1] = r.buttons[7:0];
            bytes[2] = {leds_q, ir_q, spk_q, 1'b0, r.batt_low};
            bytes[5] = r.batt_level;
        end else if (kind == FRAME_ACK) begin
            size     = ACK_SIZE;
            bytes[0] = r.buttons[15:8];
            bytes[1] = r.buttons[7:0];
            bytes[2] = r.req_id;
            bytes[3] = r.byte_value;
        end

        if (kind == FRAME_ERROR) begin
            b = {id, 5'd0, 8'd0, 1'b1, err};
            expected_beats.push_back(b);
        end else begin
            for (int k = 0; k < size; k++) begin
                b.id   = id;
                b.idx  = 5'(k);
                b.data = bytes[k];
                b.last = (k == size - 1);
                b.err  = E_NONE;
                expected_beats.push_back(b);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("ERROR @%0t %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // request driver
    t_request drive_req;
    int       send_gap = 0;
    bit       hold_for_drain = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_report(drive_req);
                reqs_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (hold_for_drain && expected_beats.size() != 0) begin
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    hold_for_drain = 1'b0;
                    drive_req = pending_reqs.pop_front();
                    i_opcode          <= drive_req.opcode;
                    i_req_id          <= drive_req.req_id;
                    i_report_is_input <= drive_req.report_is_input;
                    i_buttons         <= drive_req.buttons;
                    i_accel_x         <= drive_req.accel_x;
                    i_accel_y         <= drive_req.accel_y;
                    i_accel_z         <= drive_req.accel_z;
                    i_batt_level      <= drive_req.batt_level;
                    i_batt_low        <= drive_req.batt_low;
                    i_ext_index       <= drive_req.ext_index;
                    i_byte_value      <= drive_req.byte_value;
                    i_in_valid        <= 1'b1;
                    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                        send_gap = $urandom_range(1, 18);
                    if (idle_pct != 0 && $urandom_range(0, 39) == 0)
                        hold_for_drain = 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // report beat monitor
    t_report_beat want_beat;
    int           stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat, id", o_sent_id, '0);
                end else begin
                    want_beat = expected_beats.pop_front();
                    if (o_sent_id !== want_beat.id)
                        report_mismatch("sent_id", o_sent_id, want_beat.id);
                    if (o_byte_index !== want_beat.idx)
                        report_mismatch("byte_index", o_byte_index, want_beat.idx);
                    if (o_data_byte !== want_beat.data)
                        report_mismatch("data_byte", o_data_byte, want_beat.data);
                    if (o_last_byte !== want_beat.last)
                        report_mismatch("last_byte", o_last_byte, want_beat.last);
                    if (o_error_code !== want_beat.err)
                        report_mismatch("error_code", o_error_code, want_beat.err);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
                stall_left = $urandom_range(0, 17);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    task automatic queue_request(input t_request r);
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    task automatic wait_drained();
        while (reqs_accepted != reqs_queued || expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [5:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        case (index)
            CFG_MODE:    mode_q = value;
            CFG_LEDS:    leds_q = value[3:0];
            CFG_IR:      ir_q   = value[0];
            CFG_SPEAKER: spk_q  = value[0];
            default: ;
        endcase
    endtask

    function automatic t_request random_request();
        t_request r;
        int       pick;
        r.opcode          = OP_WRITE_EXT;
        r.req_id          = 8'($urandom_range(0, 255));
        r.report_is_input = ($urandom_range(0, 15) != 0);
        r.buttons         = 16'($urandom_range(0, 65535));
        r.accel_x         = 8'($urandom_range(0, 255));
        r.accel_y         = 8'($urandom_range(0, 255));
        r.accel_z         = 8'($urandom_range(0, 255));
        r.batt_level      = 8'($urandom_range(0, 255));
        r.batt_low        = 1'($urandom_range(0, 1));
        r.ext_index       = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(21, 31))
                                                        : 5'($urandom_range(0, 20));
        r.byte_value      = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 20)      r.opcode = OP_WRITE_EXT;
        else if (pick < 45) r.opcode = OP_DATA;
        else if (pick < 60) r.opcode = OP_STATUS;
        else if (pick < 73) r.opcode = OP_ACK;
        else if (pick < 95) r.opcode = OP_GET_REPORT;
        else                r.opcode = OP_GET_REPORT + 3'($urandom_range(1, 3));
        if (r.opcode == OP_GET_REPORT) begin
            pick = $urandom_range(0, 9);
            if (pick < 2)      r.req_id = ID_STATUS + 8'($urandom_range(0, 2));
            else if (pick < 7) r.req_id = {ID_DATA_HI, 4'($urandom_range(0, 15))};
        end
        return r;
    endfunction

    task automatic run_phases();
        t_request   r;
        logic [5:0] modes [PHASES];
        modes = '{6'h30, 6'h31, 6'h32, 6'h33, 6'h34, 6'h35, 6'h36, 6'h37,
                  6'h38, 6'h00, 6'h3d, 6'h3e, 6'h3f};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 20;

        // directed: store edges, every defined opcode, undefined opcodes 5 and 7, get-report corner ids
        r = '0; r.opcode = OP_WRITE_EXT; r.ext_index = 5'd0;  r.byte_value = 8'hFF;
        queue_request(r);
        r.ext_index = 5'd20; r.byte_value = 8'hA5; queue_request(r);
        r.ext_index = 5'd21; r.byte_value = 8'h5A; queue_request(r);
        r.ext_index = 5'd31; r.byte_value = 8'h3C; queue_request(r);
        r = '0; r.opcode = OP_DATA; r.buttons = 16'hFFFF; queue_request(r);
        r = '0; r.opcode = OP_STATUS; r.buttons = 16'hA55A; r.batt_level = 8'hFF;
        r.batt_low = 1'b1; queue_request(r);
        r = '0; r.opcode = OP_STATUS; queue_request(r);
        r = '0; r.opcode = OP_ACK; r.buttons = 16'hFFFF; r.req_id = 8'hFF;
        r.byte_value = 8'hFF; queue_request(r);
        r = '0; r.opcode = OP_ACK; queue_request(r);
        r = '0; r.opcode = OP_GET_REPORT; r.req_id = ID_STATUS; queue_request(r);
        r.report_is_input = 1'b1; r.batt_low = 1'b1; r.buttons = 16'h8001;
        r.batt_level = 8'h7F; queue_request(r);
        r.req_id = ID_READ; queue_request(r);
        r.req_id = ID_ACK;  queue_request(r);
        r.accel_x = 8'hFF; r.accel_y = 8'h00; r.accel_z = 8'h80;
        r.req_id = 8'h37; queue_request(r);
        r.req_id = 8'h33; queue_request(r);
        r.req_id = 8'h3d; queue_request(r);
        r.req_id = 8'h3f; queue_request(r);
        r.req_id = 8'h38; queue_request(r);
        r.req_id = 8'h3c; queue_request(r);
        r.req_id = 8'h00; queue_request(r);
        r.req_id = 8'hFF; queue_request(r);
        r = '0; r.opcode = OP_GET_REPORT + 3'd1; queue_request(r);
        r.opcode = OP_GET_REPORT + 3'd3; r.req_id = 8'hFF; r.byte_value = 8'hFF;
        queue_request(r);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_reg(CFG_MODE, modes[p]);
            if (p == 0)
                write_reg(CFG_LEDS, 6'd0);
            else if (p == PHASES - 1)
                write_reg(CFG_LEDS, 6'd15);
            else
                write_reg(CFG_LEDS, 6'($urandom_range(0, 15)));
            write_reg(CFG_IR, (p == 0) ? 6'd0 : (p == PHASES - 1) ? 6'd1
                                              : 6'($urandom_range(0, 1)));
            write_reg(CFG_SPEAKER, (p == 0) ? 6'd0 : (p == PHASES - 1) ? 6'd1
                                                   : 6'($urandom_range(0, 1)));
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b0;
            idle_pct = (p == 4 || p == PHASES - 1) ? 0 : 25;
            for (int k = 0; k < PHASE_REQS; k++) queue_request(random_request());
        end
        wait_drained();
    endtask

    initial begin
        fork
            run_phases();
            begin
                wait (stuck_cycles >= STUCK_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
